// ----- hdl/bki_pkg.sv -----
// Shared types and fixed constants of the bounding-box keyframe interpolator.
`default_nettype none

package bki_pkg;

  localparam int FRAME_COUNT_BITS = 7;
  localparam int NUM_COORDS       = 4;

  localparam logic CURVE_LINEAR = 1'b0;
  localparam logic CURVE_SMOOTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_ISSUE  = 3'b100
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- hdl/bki_if.sv -----
// Valid/ready channel interfaces for keyframe requests and frame boxes.
`default_nettype none

interface bki_key_if import bki_pkg::*; #(
  parameter int COORD_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  start_w;
  logic signed [COORD_BITS-1:0]  start_h;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [COORD_BITS-1:0]  end_w;
  logic signed [COORD_BITS-1:0]  end_h;
  logic [FRAME_COUNT_BITS-1:0]   frame_count;
  logic                          curve_mode;

  modport source (
    output valid, start_x, start_y, start_w, start_h,
           end_x, end_y, end_w, end_h, frame_count, curve_mode,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_w, start_h,
           end_x, end_y, end_w, end_h, frame_count, curve_mode,
    output ready
  );
endinterface

interface bki_frame_if #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 6
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  box_x;
  logic signed [COORD_BITS-1:0]  box_y;
  logic signed [COORD_BITS-1:0]  box_w;
  logic signed [COORD_BITS-1:0]  box_h;
  logic [INDEX_BITS-1:0]         frame_number;
  logic                          last_frame;

  modport source (
    output valid, box_x, box_y, box_w, box_h, frame_number, last_frame,
    input  ready
  );

  modport sink (
    input  valid, box_x, box_y, box_w, box_h, frame_number, last_frame,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/bbox_keyframe_interpolator.sv -----
// Top level: keyframe box interpolator, linear or smoothstep, pipelined per frame.
//
//   channel  dir  word                                            handshake
//   keys     in   start box, end box, frame_count, curve_mode     valid/ready
//   frames   out  box x/y/w/h, frame_number, last_frame           valid/ready
//
// A request is taken only while the sequencer is idle. A count of one goes
// straight to frame issue; a larger count first runs a radix-2 divider for
// 2^FRAC_BITS / (count-1), one quotient bit per cycle. The sequencer then
// issues one frame per cycle while the output is not stalled; a zero count
// issues no frame and leaves the sequencer idle. Each frame leaves four
// stages after issue.
// A stalled output freezes every stage and the frame counter; nothing drops.
// rst is synchronous and clears the sequencer and all valid bits only.
`default_nettype none

module bbox_keyframe_interpolator import bki_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  bki_key_if.sink     keys,
  bki_frame_if.source frames
);

  localparam int IW  = $clog2(MAX_FRAMES);        // frame index
  localparam int NW  = $clog2(MAX_FRAMES + 1);    // frame count
  localparam int TW  = FRAC_BITS + 1;             // weight, 0 .. one
  localparam int KW  = FRAC_BITS + 2;             // 3 - 2t
  localparam int DW  = COORD_BITS + 1;            // start-to-end delta
  localparam int PW  = DW + TW + 1;               // delta * weight
  localparam int SW  = PW - FRAC_BITS;            // product after floor shift
  localparam int VW  = SW + 1;                    // start + shifted product
  localparam int DCW = $clog2(TW);                // divider step counter

  localparam logic [TW-1:0]  ONE_T     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [KW-1:0]  THREE_T   = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [DCW-1:0] LAST_STEP = DCW'(TW - 1);
  localparam logic [FRAME_COUNT_BITS-1:0] MAX_FC = FRAME_COUNT_BITS'(MAX_FRAMES);

  // ---------------------------------------------------------------------
  // Request capture and sequencer
  // ---------------------------------------------------------------------
  ctrl_state_t state;

  logic signed [COORD_BITS-1:0] held_start [NUM_COORDS];
  logic signed [DW-1:0]         held_delta [NUM_COORDS];
  logic [NW-1:0]                held_count;
  logic                         held_mode;
  logic [IW-1:0]                held_div;       // count - 1

  logic [DCW-1:0] div_step;
  logic [IW:0]    div_rem;                      // remainder, then step remainder
  logic [TW-1:0]  div_quo;                      // quotient, then step quotient

  logic [TW-1:0]  t_acc;                        // running weight of next frame
  logic [IW:0]    r_acc;                        // running remainder
  logic [IW-1:0]  frame_counter;

  logic                          en;
  logic                          key_fire;
  logic                          issue_fire;
  logic                          issue_last;
  logic [FRAME_COUNT_BITS-1:0]   fc_clamp;
  logic [NW-1:0]                 n_clamp;
  logic signed [COORD_BITS-1:0]  key_start [NUM_COORDS];
  logic signed [COORD_BITS-1:0]  key_end   [NUM_COORDS];
  logic [IW:0]                   rem_sh;
  logic                          qbit;
  logic [IW:0]                   r_sum;
  logic                          carry;

  // The whole frame pipeline advances together whenever the output
  // register is empty or being drained.
  logic o_valid;
  assign en = !o_valid || frames.ready;

  // Hold off requests while in reset so no word is taken and then dropped.
  assign keys.ready = (state == ST_IDLE) && !rst;
  assign key_fire   = keys.valid && keys.ready;
  assign issue_fire = (state == ST_ISSUE) && en;
  assign issue_last = ({1'b0, frame_counter} + NW'(1)) == held_count;

  assign key_start[0] = keys.start_x;
  assign key_start[1] = keys.start_y;
  assign key_start[2] = keys.start_w;
  assign key_start[3] = keys.start_h;
  assign key_end[0]   = keys.end_x;
  assign key_end[1]   = keys.end_y;
  assign key_end[2]   = keys.end_w;
  assign key_end[3]   = keys.end_h;

  always_comb begin
    fc_clamp = (keys.frame_count > MAX_FC) ? MAX_FC : keys.frame_count;
    n_clamp  = NW'(fc_clamp);

    // Restoring division of 2^FRAC_BITS: the dividend's only set bit
    // enters on the first step.
    rem_sh = {div_rem[IW-1:0], (div_step == '0)};
    qbit   = (rem_sh >= {1'b0, held_div});

    // Weight step: t(i+1) = t(i) + Q, plus one when the remainder wraps.
    r_sum  = r_acc + div_rem;
    carry  = (r_sum >= {1'b0, held_div});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (key_fire) begin
            if (n_clamp == NW'(1)) begin
              state <= ST_ISSUE;
            end else if (n_clamp != '0) begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_step == LAST_STEP) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (issue_fire && issue_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer payload: no reset needed, always loaded before use.
  always_ff @(posedge clk) begin
    if (key_fire) begin
      for (int j = 0; j < NUM_COORDS; j++) begin
        held_start[j] <= key_start[j];
        held_delta[j] <= DW'(key_end[j]) - DW'(key_start[j]);
      end
      held_count    <= n_clamp;
      held_mode     <= keys.curve_mode;
      held_div      <= IW'(n_clamp - NW'(1));
      div_step      <= '0;
      div_rem       <= '0;
      div_quo       <= '0;
      t_acc         <= '0;
      r_acc         <= '0;
      frame_counter <= '0;
    end else if (state == ST_DIVIDE) begin
      div_step <= div_step + DCW'(1);
      div_rem  <= qbit ? (rem_sh - {1'b0, held_div}) : rem_sh;
      div_quo  <= {div_quo[TW-2:0], qbit};
    end else if (issue_fire) begin
      t_acc         <= t_acc + div_quo + TW'(carry);
      r_acc         <= carry ? (r_sum - {1'b0, held_div}) : r_sum;
      frame_counter <= frame_counter + IW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Frame pipeline
  //   G : issued frame (weight t, index, last flag, box data)
  //   S1: t*t and 3 - 2t
  //   S2: blend weight s
  //   S3: delta * s per coordinate
  //   O : floor shift, add start, saturate
  // ---------------------------------------------------------------------
  logic                         g_valid, s1_valid, s2_valid, s3_valid;

  logic [TW-1:0]                g_t;
  logic [IW-1:0]                g_i;
  logic                         g_last;
  logic                         g_mode;
  logic signed [COORD_BITS-1:0] g_start [NUM_COORDS];
  logic signed [DW-1:0]         g_delta [NUM_COORDS];

  logic [TW-1:0]                s1_t;
  logic [TW-1:0]                s1_t2;
  logic [KW-1:0]                s1_k;
  logic                         s1_mode;
  logic [IW-1:0]                s1_i;
  logic                         s1_last;
  logic signed [COORD_BITS-1:0] s1_start [NUM_COORDS];
  logic signed [DW-1:0]         s1_delta [NUM_COORDS];

  logic [TW-1:0]                s2_s;
  logic [IW-1:0]                s2_i;
  logic                         s2_last;
  logic signed [COORD_BITS-1:0] s2_start [NUM_COORDS];
  logic signed [DW-1:0]         s2_delta [NUM_COORDS];

  logic signed [PW-1:0]         s3_prod  [NUM_COORDS];
  logic [IW-1:0]                s3_i;
  logic                         s3_last;
  logic signed [COORD_BITS-1:0] s3_start [NUM_COORDS];

  logic signed [COORD_BITS-1:0] o_box [NUM_COORDS];
  logic [IW-1:0]                o_i;
  logic                         o_last;

  logic [2*TW-1:0]              sq_full;
  logic [TW+KW-1:0]             sm_full;
  logic [TW-1:0]                s_weight;
  logic signed [PW-1:0]         prod [NUM_COORDS];
  logic signed [SW-1:0]         shf  [NUM_COORDS];
  logic signed [VW-1:0]         vsum [NUM_COORDS];
  logic signed [COORD_BITS-1:0] vsat [NUM_COORDS];

  always_comb begin
    sq_full  = (2*TW)'(g_t) * (2*TW)'(g_t);
    sm_full  = (TW+KW)'(s1_t2) * (TW+KW)'(s1_k);
    s_weight = (s1_mode == CURVE_SMOOTH) ? sm_full[FRAC_BITS +: TW] : s1_t;
    for (int j = 0; j < NUM_COORDS; j++) begin
      prod[j] = $signed(PW'(s2_delta[j])) * $signed(PW'({1'b0, s2_s}));
      // Arithmetic shift floors toward minus infinity.
      shf[j]  = SW'(s3_prod[j] >>> FRAC_BITS);
      vsum[j] = VW'(s3_start[j]) + VW'(shf[j]);
      // Clamp when the top bits are not all copies of the sign.
      if ((&vsum[j][VW-1:COORD_BITS-1]) || !(|vsum[j][VW-1:COORD_BITS-1])) begin
        vsat[j] = vsum[j][COORD_BITS-1:0];
      end else if (vsum[j][VW-1]) begin
        vsat[j] = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        vsat[j] = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (en) begin
      g_valid  <= issue_fire;
      s1_valid <= g_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      o_valid  <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_t    <= t_acc;
      g_i    <= frame_counter;
      g_last <= issue_last;
      g_mode <= held_mode;

      s1_t    <= g_t;
      s1_t2   <= sq_full[FRAC_BITS +: TW];
      s1_k    <= THREE_T - {g_t, 1'b0};
      s1_mode <= g_mode;
      s1_i    <= g_i;
      s1_last <= g_last;

      s2_s    <= s_weight;
      s2_i    <= s1_i;
      s2_last <= s1_last;

      s3_i    <= s2_i;
      s3_last <= s2_last;

      o_i    <= s3_i;
      o_last <= s3_last;

      for (int j = 0; j < NUM_COORDS; j++) begin
        g_start[j]  <= held_start[j];
        g_delta[j]  <= held_delta[j];
        s1_start[j] <= g_start[j];
        s1_delta[j] <= g_delta[j];
        s2_start[j] <= s1_start[j];
        s2_delta[j] <= s1_delta[j];
        s3_start[j] <= s2_start[j];
        s3_prod[j]  <= prod[j];
        o_box[j]    <= vsat[j];
      end
    end
  end

  assign frames.valid        = o_valid;
  assign frames.box_x        = o_box[0];
  assign frames.box_y        = o_box[1];
  assign frames.box_w        = o_box[2];
  assign frames.box_h        = o_box[3];
  assign frames.frame_number = o_i;
  assign frames.last_frame   = o_last;

`ifndef SYNTHESIS
  // The running weight never passes one while a frame is in flight.
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    g_valid |-> (g_t <= ONE_T))
    else $error("frame weight above one");

  // The final frame of a multi-frame run lands exactly on the end box.
  a_last_weight: assert property (@(posedge clk) disable iff (rst)
    (g_valid && g_last && (g_i != '0)) |-> (g_t == ONE_T))
    else $error("last frame weight is not one");

  // A single-frame request skips the divider.
  a_single_skip: assert property (@(posedge clk) disable iff (rst)
    (key_fire && (keys.frame_count == FRAME_COUNT_BITS'(1))) |=> (state == ST_ISSUE))
    else $error("single-frame request did not go straight to issue");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_bbox_keyframe_interpolator.sv -----
// Self-checking testbench for the keyframe box interpolator: predicts every frame box.
`timescale 1ns / 1ps

package bki_tb_pkg;
  import bki_pkg::*;

  localparam int          COORD_BITS = 24;
  localparam int          FRAC_BITS  = 16;
  localparam int unsigned MAX_FRAMES = 64;
  localparam bit [63:0]   ONE_T      = 64'd1 << FRAC_BITS;
  localparam longint      COORD_HI   = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint      COORD_LO   = -COORD_HI - 1;
  localparam int          REPORT_MAX = 10;

  typedef struct {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_w;
    logic signed [COORD_BITS-1:0] start_h;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_w;
    logic signed [COORD_BITS-1:0] end_h;
    logic [FRAME_COUNT_BITS-1:0]  frame_count;
    logic                         curve_mode;
  } key_word_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic signed [COORD_BITS-1:0] box_w;
    logic signed [COORD_BITS-1:0] box_h;
    logic [5:0]                   frame_number;
    logic                         last_frame;
  } frame_word_t;

  class box_scoreboard;
    frame_word_t  expected_boxes[$];
    int unsigned  mismatches = 0;
    longint       held_start[4];
    longint       held_delta[4];
    int unsigned  held_count = 0;
    logic         held_mode  = CURVE_LINEAR;

    // Blend weight in Q1.16: linear t, or smoothstep t*t*(3-2t), truncated.
    function bit [63:0] blend_weight(int unsigned idx, int unsigned n, logic mode);
      bit [63:0] t;
      bit [63:0] t2;
      bit [63:0] k;
      if (n <= 1) return 64'd0;
      t = (64'(idx) << FRAC_BITS) / 64'(n - 1);
      if (mode == CURVE_LINEAR) return t;
      t2 = (t * t) >> FRAC_BITS;
      k  = 3 * ONE_T - 2 * t;
      return (t2 * k) >> FRAC_BITS;
    endfunction

    function longint clamp_coord(longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
    endfunction

    // Expand one accepted request into its frame boxes.
    function void note_request(key_word_t k);
      frame_word_t f;
      longint      coord[4];
      longint      ends[4];
      bit [63:0]   s;
      held_start[0] = longint'(k.start_x);
      held_start[1] = longint'(k.start_y);
      held_start[2] = longint'(k.start_w);
      held_start[3] = longint'(k.start_h);
      ends[0] = longint'(k.end_x);
      ends[1] = longint'(k.end_y);
      ends[2] = longint'(k.end_w);
      ends[3] = longint'(k.end_h);
      for (int j = 0; j < 4; j++) held_delta[j] = ends[j] - held_start[j];
      held_count = 32'(k.frame_count);
      if (held_count > MAX_FRAMES) held_count = MAX_FRAMES;
      held_mode = k.curve_mode;
      for (int unsigned i = 0; i < held_count; i++) begin
        s = blend_weight(i, held_count, held_mode);
        for (int j = 0; j < 4; j++) begin
          // arithmetic shift floors toward minus infinity
          coord[j] = clamp_coord(held_start[j] + ((held_delta[j] * longint'(s)) >>> FRAC_BITS));
        end
        f.box_x        = coord[0][COORD_BITS-1:0];
        f.box_y        = coord[1][COORD_BITS-1:0];
        f.box_w        = coord[2][COORD_BITS-1:0];
        f.box_h        = coord[3][COORD_BITS-1:0];
        f.frame_number = i[5:0];
        f.last_frame   = (i + 1 == held_count);
        expected_boxes = {expected_boxes, f};
      end
    endfunction

    function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_box(frame_word_t got);
      frame_word_t want;
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: frame %0d arrived with nothing expected", $time, got.frame_number);
        return;
      end
      want = expected_boxes.pop_front();
      if (got.box_x !== want.box_x) flag("box_x", 32'(want.box_x), 32'(got.box_x));
      if (got.box_y !== want.box_y) flag("box_y", 32'(want.box_y), 32'(got.box_y));
      if (got.box_w !== want.box_w) flag("box_w", 32'(want.box_w), 32'(got.box_w));
      if (got.box_h !== want.box_h) flag("box_h", 32'(want.box_h), 32'(got.box_h));
      if (got.frame_number !== want.frame_number)
        flag("frame_number", 32'(want.frame_number), 32'(got.frame_number));
      if (got.last_frame !== want.last_frame)
        flag("last_frame", 32'(want.last_frame), 32'(got.last_frame));
    endfunction

    function int unsigned pending();
      return expected_boxes.size();
    endfunction
  endclass
endpackage

module tb_bbox_keyframe_interpolator;
  import bki_pkg::*;
  import bki_tb_pkg::*;

  localparam int          RANDOM_ITEMS = 104;
  localparam int          PHASE_ITEMS  = 26;
  localparam int          HOLD_OFF     = 400;
  // idle gap after the last frame
  localparam int          TAIL_CYCLES  = 150;
  // worst case: ~130 requests x 64 frames, each frame behind a receiver stall, taken four times
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;

  localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] C_MIN = 24'sh800000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bki_key_if   #(.COORD_BITS(COORD_BITS))                 key_ch ();
  bki_frame_if #(.COORD_BITS(COORD_BITS), .INDEX_BITS(6)) frame_ch ();

  bbox_keyframe_interpolator #(
    .MAX_FRAMES (MAX_FRAMES),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .keys   (key_ch),
    .frames (frame_ch)
  );

  box_scoreboard board = new();

  // Idling controls, set by the stimulus and read by the drivers.
  bit steady_source    = 1'b0;
  bit steady_sink      = 1'b0;
  bit hold_off_request = 1'b0;

  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note every accepted request word. Sample pre-edge values; all drives are nonblocking.
  always @(posedge clk) begin
    if (!rst && key_ch.valid === 1'b1 && key_ch.ready === 1'b1) begin
      board.note_request('{key_ch.start_x, key_ch.start_y, key_ch.start_w, key_ch.start_h,
                           key_ch.end_x, key_ch.end_y, key_ch.end_w, key_ch.end_h,
                           key_ch.frame_count, key_ch.curve_mode});
    end
  end

  // Check every accepted frame word against the oldest expected box.
  always @(posedge clk) begin
    if (!rst && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
      board.check_box('{frame_ch.box_x, frame_ch.box_y, frame_ch.box_w, frame_ch.box_h,
                        frame_ch.frame_number, frame_ch.last_frame});
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned source_gap();
    if (steady_source) return 0;
    return $urandom_range(0, 1) ? 0 : idle_len();
  endfunction

  // Receiver: random ready, a long hold-off on request, steady stretches.
  initial begin
    frame_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        frame_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (steady_sink || $urandom_range(0, 3) != 0) begin
        frame_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        frame_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  function automatic key_word_t make_key(
    logic signed [COORD_BITS-1:0] sx, logic signed [COORD_BITS-1:0] sy,
    logic signed [COORD_BITS-1:0] sw, logic signed [COORD_BITS-1:0] sh,
    logic signed [COORD_BITS-1:0] ex, logic signed [COORD_BITS-1:0] ey,
    logic signed [COORD_BITS-1:0] ew, logic signed [COORD_BITS-1:0] eh,
    logic [FRAME_COUNT_BITS-1:0] cnt, logic mode);
    key_word_t k;
    k = '{sx, sy, sw, sh, ex, ey, ew, eh, cnt, mode};
    return k;
  endfunction

  // Coordinates: extremes, small values near zero, or any 24-bit pattern.
  function automatic logic signed [COORD_BITS-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return COORD_BITS'($signed($urandom_range(0, 4095)) - 2048);
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [FRAME_COUNT_BITS-1:0] random_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return FRAME_COUNT_BITS'($urandom_range(65, 127));  // above the frame limit
    if (r <= 5) return FRAME_COUNT_BITS'($urandom_range(1, 3));
    return FRAME_COUNT_BITS'($urandom_range(1, MAX_FRAMES));
  endfunction

  function automatic key_word_t random_key();
    key_word_t k;
    k.start_x = random_coord();
    k.start_y = random_coord();
    k.start_w = random_coord();
    k.start_h = random_coord();
    // keep end boxes close to start boxes a third of the time
    if ($urandom_range(0, 2) == 0) begin
      k.end_x = k.start_x + COORD_BITS'($signed($urandom_range(0, 511)) - 256);
      k.end_y = k.start_y + COORD_BITS'($signed($urandom_range(0, 511)) - 256);
      k.end_w = k.start_w + COORD_BITS'($signed($urandom_range(0, 511)) - 256);
      k.end_h = k.start_h + COORD_BITS'($signed($urandom_range(0, 511)) - 256);
    end else begin
      k.end_x = random_coord();
      k.end_y = random_coord();
      k.end_w = random_coord();
      k.end_h = random_coord();
    end
    k.frame_count = random_count();
    k.curve_mode  = $urandom_range(0, 1) ? CURVE_SMOOTH : CURVE_LINEAR;
    return k;
  endfunction

  // Offer one request word after an idle gap; return at the edge it is accepted.
  // Leave valid high so a back-to-back word needs no second assignment.
  task automatic send_request(input key_word_t k, input int unsigned gap);
    if (gap != 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.start_x     <= k.start_x;
    key_ch.start_y     <= k.start_y;
    key_ch.start_w     <= k.start_w;
    key_ch.start_h     <= k.start_h;
    key_ch.end_x       <= k.end_x;
    key_ch.end_y       <= k.end_y;
    key_ch.end_w       <= k.end_w;
    key_ch.end_h       <= k.end_h;
    key_ch.frame_count <= k.frame_count;
    key_ch.curve_mode  <= k.curve_mode;
    key_ch.valid       <= 1'b1;
    do @(posedge clk); while (key_ch.ready !== 1'b1);
  endtask

  // Drop valid and hold until every expected box has come out.
  task automatic drain_boxes();
    key_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    int unsigned random_sent;
    key_word_t   k;

    key_ch.valid       <= 1'b0;
    key_ch.start_x     <= '0;
    key_ch.start_y     <= '0;
    key_ch.start_w     <= '0;
    key_ch.start_h     <= '0;
    key_ch.end_x       <= '0;
    key_ch.end_y       <= '0;
    key_ch.end_w       <= '0;
    key_ch.end_h       <= '0;
    key_ch.frame_count <= '0;
    key_ch.curve_mode  <= CURVE_LINEAR;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single frame at the extremes, both curves.
    send_request(make_key(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
                          1, CURVE_LINEAR), source_gap());
    send_request(make_key(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
                          1, CURVE_SMOOTH), source_gap());
    // Zero frame count: accepted, nothing comes out.
    send_request(make_key(C_MAX, 0, C_MIN, -1, 0, C_MAX, 1, C_MIN, 0, CURVE_LINEAR),
                 source_gap());
    send_request(make_key(-1, -1, -1, -1, 1, 1, 1, 1, 0, CURVE_SMOOTH), source_gap());
    // Full-range deltas at two frames and at the frame limit.
    send_request(make_key(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
                          2, CURVE_LINEAR), source_gap());
    send_request(make_key(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
                          64, CURVE_LINEAR), source_gap());
    send_request(make_key(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
                          64, CURVE_SMOOTH), source_gap());
    // Counts above the limit clamp to 64 frames.
    send_request(make_key(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          127, CURVE_SMOOTH), source_gap());
    send_request(make_key(100, -100, 0, 5000, -100, 100, 7000, 0, 65, CURVE_LINEAR),
                 source_gap());
    send_request(make_key(C_MIN, C_MAX, 0, -1, C_MAX, C_MIN, -1, 0, 96, CURVE_LINEAR),
                 source_gap());
    // Tiny deltas exercise flooring of negative products.
    send_request(make_key(0, 0, 0, 0, -1, -1, 1, 1, 3, CURVE_SMOOTH), source_gap());
    send_request(make_key(0, 0, 0, 0, 1, -1, 1, -1, 5, CURVE_LINEAR), source_gap());
    send_request(make_key(0, 0, 0, 0, -3, 3, -7, 7, 17, CURVE_SMOOTH), source_gap());
    // Start equals end: flat output. Then mixed boxes at odd frame counts.
    send_request(make_key(1234, -4321, C_MAX, C_MIN, 1234, -4321, C_MAX, C_MIN,
                          7, CURVE_SMOOTH), source_gap());
    send_request(make_key(100, -1, 0, C_MIN, -100, 0, C_MAX, 0, 33, CURVE_SMOOTH),
                 source_gap());
    send_request(make_key(-256, 256, 512, 768, 256, -256, 1024, 0, 31, CURVE_LINEAR),
                 source_gap());
    send_request(make_key(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          63, CURVE_SMOOTH), source_gap());
    drain_boxes();

    // Back pressure: hold the receiver off while full runs queue up at the input.
    hold_off_request = 1'b1;
    steady_source    = 1'b1;
    for (int i = 0; i < 4; i++) begin
      k = random_key();
      k.frame_count = FRAME_COUNT_BITS'(MAX_FRAMES);
      send_request(k, 0);
    end
    steady_source = 1'b0;
    drain_boxes();

    // Random requests in phases: random idling, no idling, mixed.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ((random_sent / PHASE_ITEMS) % 4)
        1: begin
          steady_source = 1'b1;
          steady_sink   = 1'b1;
        end
        3: begin
          steady_source = 1'b1;
          steady_sink   = 1'b0;
        end
        default: begin
          steady_source = 1'b0;
          steady_sink   = 1'b0;
        end
      endcase
      k = random_key();
      send_request(k, source_gap());
      if (k.frame_count != 0) random_sent++;
    end
    steady_sink = 1'b0;
    drain_boxes();

    // Let any stray frame surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
